[hdl/sfa_pkg.sv]
// Shared constants and types for the secp256k1 field arithmetic unit.
`default_nettype none
package sfa_pkg;
	localparam int unsigned FW = 256;
	localparam logic [FW-1:0] PRIME =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
	localparam logic [FW-1:0] EXP_INV  = PRIME - 256'd2;
	localparam logic [FW-1:0] EXP_SQRT = (PRIME + 256'd1) >> 2;

	localparam logic [2:0] FN_ADD  = 3'd0;
	localparam logic [2:0] FN_SUB  = 3'd1;
	localparam logic [2:0] FN_NEG  = 3'd2;
	localparam logic [2:0] FN_MUL  = 3'd3;
	localparam logic [2:0] FN_SQR  = 3'd4;
	localparam logic [2:0] FN_INV  = 3'd5;
	localparam logic [2:0] FN_SQRT = 3'd6;

	typedef struct packed {
		logic          go;
		logic [FW-1:0] x;
		logic [FW-1:0] y;
	} mul_req_t;

	typedef struct packed {
		logic          done;
		logic [FW-1:0] prod;
	} mul_rsp_t;
endpackage
`default_nettype wire

[hdl/sfa_req_if.sv]
// Request channel: operation code and two operands.
`default_nettype none
interface sfa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [63:0] a_w0;
	logic [63:0] a_w1;
	logic [63:0] a_w2;
	logic [63:0] a_w3;
	logic [63:0] b_w0;
	logic [63:0] b_w1;
	logic [63:0] b_w2;
	logic [63:0] b_w3;
	modport source (output valid, func, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
		input ready);
	modport sink (input valid, func, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
		output ready);
endinterface
`default_nettype wire

[hdl/sfa_rsp_if.sv]
// Response channel: field element result and fail flag.
`default_nettype none
interface sfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] res_w0;
	logic [63:0] res_w1;
	logic [63:0] res_w2;
	logic [63:0] res_w3;
	logic        fail;
	modport source (output valid, res_w0, res_w1, res_w2, res_w3, fail, input ready);
	modport sink (input valid, res_w0, res_w1, res_w2, res_w3, fail, output ready);
endinterface
`default_nettype wire

[hdl/sfa_mul.sv]
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module sfa_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfa_pkg::mul_req_t req,
	output sfa_pkg::mul_rsp_t      rsp
);
	import sfa_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic [7:0]    cnt_q;
	logic [FW-1:0] x_q;
	logic [FW-1:0] y_q;
	logic [FW-1:0] acc_q;
	logic [FW+1:0] t;
	logic [FW+2:0] d1;
	logic [FW+2:0] d2;
	logic [FW-1:0] nxt;

	// acc < p, so 2*acc + y < 3p; subtract 2p or p as fits
	always_comb begin
		t  = {1'b0, acc_q, 1'b0} + (x_q[FW-1] ? {2'b00, y_q} : '0);
		d1 = {1'b0, t} - {3'b000, PRIME};
		d2 = {1'b0, t} - {2'b00, PRIME, 1'b0};
		if (!d2[FW+2]) begin
			nxt = d2[FW-1:0];
		end else if (!d1[FW+2]) begin
			nxt = d1[FW-1:0];
		end else begin
			nxt = t[FW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'hFF;
			end else if (busy_q) begin
				if (cnt_q == 8'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q   <= req.x;
			y_q   <= req.y;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[FW-2:0], 1'b0};
			acc_q <= nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n) req.go |-> !busy_q)
		else $error("multiplier started while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("done without a finished pass");
	a_acc_red: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> acc_q < PRIME)
		else $error("product not reduced");
endmodule
`default_nettype wire

[hdl/secp256k1_field_alu_core.sv]
// Top level: secp256k1 field ALU with operand reduction, sequencer and shared multiplier.
// One request beat on req carries func and operands a, b (four 64-bit words each,
// word 0 least significant); one response beat on rsp carries res and fail.
// Items are handled one at a time: req.ready is high only while the unit is idle.
// Path from the accepting edge to rsp.valid, after S_RED and S_EXEC:
//   add, sub, neg, unused code, inverse of zero: straight on to S_OUT
//   mul, sqr: one bit-serial pass of the multiplier
//   inverse, square root: one square per exponent bit and one product per set bit;
//   square root adds one more product for the root check.
// The bit-serial multiplier sets the pace: a modular product is 256 steps
// plus start and done handoff. The next request is taken in the cycle
// after the response beat at the earliest.
// rsp.valid stays high with the result held until rsp.ready; no new request is
// taken meanwhile. Reset returns the sequencer to idle and drops rsp.valid;
// any item in flight is lost.
`default_nettype none
module secp256k1_field_alu_core (
	input  wire logic clk,
	input  wire logic arst_n,
	sfa_req_if.sink   req,
	sfa_rsp_if.source rsp
);
	import sfa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RED   = 8'b0000_0010,
		S_EXEC  = 8'b0000_0100,
		S_MWAIT = 8'b0000_1000,
		S_PSQ   = 8'b0001_0000,
		S_PMUL  = 8'b0010_0000,
		S_CHK   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [2:0]    func_q;
	logic [FW-1:0] a_q;
	logic [FW-1:0] b_q;
	logic [FW-1:0] acc_q;
	logic [FW-1:0] res_q;
	logic          fail_q;
	logic [7:0]    idx_q;
	logic          go_q;
	logic [FW-1:0] mx_q;
	logic [FW-1:0] my_q;
	mul_req_t      mreq;
	mul_rsp_t      mrsp;

	logic [FW:0]   a_m;
	logic [FW:0]   b_m;
	logic [FW:0]   sum;
	logic [FW:0]   sum_m;
	logic [FW:0]   dif;
	logic [FW-1:0] alu_res;
	logic          exp_bit;

	assign mreq.go = go_q;
	assign mreq.x  = mx_q;
	assign mreq.y  = my_q;

	sfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		a_m   = {1'b0, a_q} - {1'b0, PRIME};
		b_m   = {1'b0, b_q} - {1'b0, PRIME};
		sum   = {1'b0, a_q} + {1'b0, b_q};
		sum_m = sum - {1'b0, PRIME};
		dif   = {1'b0, a_q} - {1'b0, b_q};
		case (func_q)
			FN_ADD:  alu_res = sum_m[FW] ? sum[FW-1:0] : sum_m[FW-1:0];
			FN_SUB:  alu_res = dif[FW] ? dif[FW-1:0] + PRIME : dif[FW-1:0];
			FN_NEG:  alu_res = (a_q == '0) ? '0 : PRIME - a_q;
			default: alu_res = '0;
		endcase
		exp_bit = (func_q == FN_INV) ? EXP_INV[idx_q] : EXP_SQRT[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_RED;
				end
				S_RED: state_q <= S_EXEC;
				S_EXEC: begin
					case (func_q) inside
						FN_MUL, FN_SQR: begin
							go_q    <= 1'b1;
							state_q <= S_MWAIT;
						end
						FN_INV: begin
							if (a_q == '0) begin
								state_q <= S_OUT;
							end else begin
								go_q    <= 1'b1;
								state_q <= S_PSQ;
							end
						end
						FN_SQRT: begin
							go_q    <= 1'b1;
							state_q <= S_PSQ;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_MWAIT: begin
					if (mrsp.done) state_q <= S_OUT;
				end
				S_PSQ: begin
					if (mrsp.done) begin
						if (exp_bit) begin
							go_q    <= 1'b1;
							state_q <= S_PMUL;
						end else if (idx_q != 8'd0) begin
							go_q <= 1'b1;
						end else if (func_q == FN_SQRT) begin
							go_q    <= 1'b1;
							state_q <= S_CHK;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_PMUL: begin
					if (mrsp.done) begin
						go_q <= 1'b1;
						if (idx_q != 8'd0) begin
							state_q <= S_PSQ;
						end else if (func_q == FN_SQRT) begin
							state_q <= S_CHK;
						end else begin
							go_q    <= 1'b0;
							state_q <= S_OUT;
						end
					end
				end
				S_CHK: begin
					if (mrsp.done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				a_q    <= {req.a_w3, req.a_w2, req.a_w1, req.a_w0};
				b_q    <= {req.b_w3, req.b_w2, req.b_w1, req.b_w0};
			end
			S_RED: begin
				if (!a_m[FW]) a_q <= a_m[FW-1:0];
				if (!b_m[FW]) b_q <= b_m[FW-1:0];
			end
			S_EXEC: begin
				res_q  <= alu_res;
				fail_q <= (func_q == FN_INV) && (a_q == '0);
				acc_q  <= {{(FW-1){1'b0}}, 1'b1};
				idx_q  <= 8'hFF;
				mx_q   <= (func_q == FN_MUL || func_q == FN_SQR) ? a_q
					: {{(FW-1){1'b0}}, 1'b1};
				my_q   <= (func_q == FN_MUL) ? b_q
					: (func_q == FN_SQR) ? a_q : {{(FW-1){1'b0}}, 1'b1};
			end
			S_MWAIT: begin
				if (mrsp.done) res_q <= mrsp.prod;
			end
			S_PSQ: begin
				if (mrsp.done) begin
					acc_q <= mrsp.prod;
					res_q <= mrsp.prod;
					mx_q  <= mrsp.prod;
					if (exp_bit) begin
						my_q <= a_q;
					end else begin
						my_q  <= mrsp.prod;
						idx_q <= idx_q - 8'd1;
					end
				end
			end
			S_PMUL: begin
				if (mrsp.done) begin
					acc_q <= mrsp.prod;
					res_q <= mrsp.prod;
					mx_q  <= mrsp.prod;
					my_q  <= mrsp.prod;
					idx_q <= idx_q - 8'd1;
				end
			end
			S_CHK: begin
				if (mrsp.done) fail_q <= (mrsp.prod != a_q);
			end
			S_OUT: ;
			default: ;
		endcase
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = (state_q == S_OUT);
	assign rsp.res_w0 = res_q[63:0];
	assign rsp.res_w1 = res_q[127:64];
	assign rsp.res_w2 = res_q[191:128];
	assign rsp.res_w3 = res_q[255:192];
	assign rsp.fail   = fail_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while a result is pending");
	a_fail_ops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fail |-> func_q == FN_INV || func_q == FN_SQRT)
		else $error("fail raised for an operation that cannot fail");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> state_q == S_MWAIT || state_q == S_PSQ || state_q == S_PMUL
			|| state_q == S_CHK)
		else $error("product returned with no one waiting");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_RED)
		else $error("accepted request not processed");
endmodule
`default_nettype wire
